[src/indexed_ordered_list_macros.svh]
// Assertion macros for the indexed ordered list.
// Each macro expects a clock named clk and an active-low reset named arst_n in scope.
`ifndef INDEXED_ORDERED_LIST_MACROS_SVH
`define INDEXED_ORDERED_LIST_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define IOL_ASSERT_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define IOL_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[src/iol_pkg.sv]
// ----------------------------------------------------------------------------
// iol_pkg
// Shared widths, command and status codes, and the cell command bundle.
// ----------------------------------------------------------------------------
package iol_pkg;

	localparam int CAPACITY_DEF = 16;

	localparam int OP_W     = 3;
	localparam int INDEX_W  = 6;
	localparam int VALUE_W  = 64;
	localparam int STATUS_W = 2;
	localparam int POS_W    = 4;
	localparam int COUNT_W  = 5;

	typedef enum logic [OP_W-1:0] {
		OP_INSERT = 3'd0,
		OP_REMOVE = 3'd1,
		OP_FIND   = 3'd2,
		OP_READ   = 3'd3,
		OP_CLEAR  = 3'd4
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		STS_OK        = 2'd0,
		STS_BAD_INDEX = 2'd1,
		STS_NOT_FOUND = 2'd2,
		STS_FULL      = 2'd3
	} status_t;

	// What every cell does in the coming cycle; all zero means hold.
	typedef struct packed {
		logic ins;  // open a gap at the index and load the new word there
		logic rem;  // close the gap at the index
		logic rot;  // rotate the whole ring by one place toward cell zero
	} cell_cmd_t;

endpackage

[src/indexed_ordered_list.sv]
// ----------------------------------------------------------------------------
// indexed_ordered_list
// Bounded ordered list of 64-bit words held in a ring of shifting cells.
// ----------------------------------------------------------------------------
// A request is taken on a rising edge where start is high and busy is low, and
// every request gives exactly one result, shown for a single cycle with done
// high. The receiver cannot stall, so capture the result ports whenever done
// is high. Insert, remove, clear, unused op codes and every request that fails
// its index check need no scan: done rises in the cycle after the request,
// busy stays low, and a new request may follow on every cycle. A find, and a
// read at a valid index, rotate the ring of CAPACITY cells once past the
// comparator on cell zero: busy is high while the ring rotates and done comes
// in the cycle after the last step, with the next request taken in the cycle
// done is high. Count reports the number of entries after the request,
// truncated to five bits, and position the low four bits of the found
// position.
// ----------------------------------------------------------------------------
`include "indexed_ordered_list_macros.svh"

module indexed_ordered_list
	import iol_pkg::*;
#(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic [OP_W-1:0]     op,
	input  logic [INDEX_W-1:0]  index,
	input  logic [VALUE_W-1:0]  value,
	output logic                done,
	output logic [STATUS_W-1:0] status,
	output logic [POS_W-1:0]    position,
	output logic [VALUE_W-1:0]  data,
	output logic [COUNT_W-1:0]  count
);

	// Count needs to reach CAPACITY itself; comparisons run at a width that
	// covers both the count and any nonnegative index.
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int SW = $clog2(CAPACITY);
	localparam int KW = (CW > INDEX_W - 1) ? CW : INDEX_W - 1;

	localparam logic [CW-1:0] CNT_FULL  = CW'(CAPACITY);
	localparam logic [SW-1:0] STEP_LAST = SW'(CAPACITY - 1);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_SCAN = 2'b10
	} state_t;

	state_t state_q, state_d;
	logic [CW-1:0] cnt_q, cnt_d;
	logic [SW-1:0] step_q, step_d;
	logic          done_q, done_d;

	// Scan context, captured with the request.
	logic               is_find_q;
	logic [KW-1:0]      idx_q;
	logic [VALUE_W-1:0] value_q;
	logic               hit_q, hit_d;
	logic [SW-1:0]      hpos_q, hpos_d;
	logic [VALUE_W-1:0] rdata_q, rdata_d;

	// Result registers.
	logic [STATUS_W-1:0] status_q, status_d;
	logic [POS_W-1:0]    position_q, position_d;
	logic [VALUE_W-1:0]  data_q, data_d;

	logic                accept;
	logic                neg;
	logic [KW-1:0]       idx_k;
	logic [KW-1:0]       cnt_k;
	logic                go_scan;
	cell_cmd_t           cmd;
	logic [VALUE_W-1:0]  cell_q [CAPACITY];

	logic                scan_last;
	logic                in_range;
	logic                match;
	logic                rd_hit;

	assign accept = start && (state_q == ST_IDLE);
	assign neg    = index[INDEX_W-1];
	assign idx_k  = KW'(index[INDEX_W-2:0]);
	assign cnt_k  = KW'(cnt_q);

	// Cell zero holds the entry at position step_q while the ring rotates.
	assign scan_last = (state_q == ST_SCAN) && (step_q == STEP_LAST);
	assign in_range  = KW'(step_q) < cnt_k;
	assign match     = is_find_q && !hit_q && in_range && (cell_q[0] == value_q);
	assign rd_hit    = !is_find_q && (KW'(step_q) == idx_q);

	always_comb begin
		state_d    = state_q;
		cnt_d      = cnt_q;
		step_d     = step_q;
		done_d     = 1'b0;
		go_scan    = 1'b0;
		cmd        = '0;
		hit_d      = hit_q;
		hpos_d     = hpos_q;
		rdata_d    = rdata_q;
		status_d   = status_q;
		position_d = position_q;
		data_d     = data_q;

		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					done_d     = 1'b1;
					status_d   = STS_OK;
					position_d = '0;
					data_d     = '0;
					unique case (op)
						OP_INSERT: begin
							if (neg || (idx_k > cnt_k)) begin
								status_d = STS_BAD_INDEX;
							end else if (cnt_q == CNT_FULL) begin
								status_d = STS_FULL;
							end else begin
								cmd.ins = 1'b1;
								cnt_d   = cnt_q + CW'(1);
							end
						end
						OP_REMOVE: begin
							if (neg || (idx_k >= cnt_k)) begin
								status_d = STS_BAD_INDEX;
							end else begin
								cmd.rem = 1'b1;
								cnt_d   = cnt_q - CW'(1);
							end
						end
						OP_FIND: begin
							go_scan = 1'b1;
						end
						OP_READ: begin
							if (neg || (idx_k >= cnt_k)) begin
								status_d = STS_BAD_INDEX;
							end else begin
								go_scan = 1'b1;
							end
						end
						OP_CLEAR: begin
							cnt_d = '0;
						end
						default: begin
						end
					endcase
					if (go_scan) begin
						done_d  = 1'b0;
						state_d = ST_SCAN;
						step_d  = '0;
						hit_d   = 1'b0;
						hpos_d  = '0;
						rdata_d = '0;
					end
				end
			end
			ST_SCAN: begin
				cmd.rot = 1'b1;
				if (match) begin
					hit_d  = 1'b1;
					hpos_d = step_q;
				end
				if (rd_hit) begin
					rdata_d = cell_q[0];
				end
				if (scan_last) begin
					state_d  = ST_IDLE;
					done_d   = 1'b1;
					status_d = STS_OK;
					position_d = '0;
					data_d     = '0;
					if (is_find_q) begin
						if (hit_q) begin
							position_d = POS_W'(hpos_q);
						end else if (match) begin
							position_d = POS_W'(step_q);
						end else begin
							status_d = STS_NOT_FOUND;
						end
					end else begin
						data_d = rd_hit ? cell_q[0] : rdata_q;
					end
				end else begin
					step_d = step_q + SW'(1);
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			step_q  <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			step_q  <= step_d;
			done_q  <= done_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			is_find_q <= (op == OP_FIND);
			idx_q     <= idx_k;
			value_q   <= value;
		end
		hit_q      <= hit_d;
		hpos_q     <= hpos_d;
		rdata_q    <= rdata_d;
		status_q   <= status_d;
		position_q <= position_d;
		data_q     <= data_d;
	end

	// The ring: each cell sees both neighbors, with wrap-around so that a full
	// rotation brings every entry back to its own cell.
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		iol_cell #(
			.KW  (KW),
			.POS (i)
		) u_cell (
			.clk   (clk),
			.cmd   (cmd),
			.idx   (idx_k),
			.value (value),
			.lower (cell_q[(i + CAPACITY - 1) % CAPACITY]),
			.upper (cell_q[(i + 1) % CAPACITY]),
			.q     (cell_q[i])
		);
	end

	assign busy     = (state_q == ST_SCAN);
	assign done     = done_q;
	assign status   = status_q;
	assign position = position_q;
	assign data     = data_q;
	assign count    = COUNT_W'(cnt_q);

	// No result may appear while the ring is still rotating.
	`IOL_ASSERT_IMPLY(a_no_done_in_scan, state_q == ST_SCAN, !done_q, "result during scan")
	// The list never holds more entries than it has cells.
	`IOL_ASSERT_IMPLY(a_count_bound, 1'b1, cnt_q <= CNT_FULL, "count above capacity")
	// A request that needs no scan answers in the next cycle.
	`IOL_ASSERT_NEXT(a_quick_result, accept && !go_scan, done_q, "missing quick result")
	// Every result comes from a request or from the end of a scan.
	`IOL_ASSERT_IMPLY(a_result_source, done_q, $past(accept) || $past(scan_last), "stray result")

endmodule

[src/iol_cell.sv]
// ----------------------------------------------------------------------------
// iol_cell
// One list slot: holds one word and takes its next value from itself, from
// its lower or upper neighbor, or from the broadcast word.
// ----------------------------------------------------------------------------
module iol_cell
	import iol_pkg::*;
#(
	parameter int KW  = 5,
	parameter int POS = 0
) (
	input  logic               clk,
	input  cell_cmd_t          cmd,
	input  logic [KW-1:0]      idx,
	input  logic [VALUE_W-1:0] value,
	input  logic [VALUE_W-1:0] lower,
	input  logic [VALUE_W-1:0] upper,
	output logic [VALUE_W-1:0] q
);

	localparam logic [KW-1:0] MY_POS = KW'(POS);

	logic [VALUE_W-1:0] entry_q;
	logic [VALUE_W-1:0] entry_d;

	always_comb begin
		entry_d = entry_q;
		priority if (cmd.rot) begin
			entry_d = upper;
		end else if (cmd.ins) begin
			if (MY_POS == idx) begin
				entry_d = value;
			end else if (MY_POS > idx) begin
				entry_d = lower;
			end
		end else if (cmd.rem) begin
			if (MY_POS >= idx) begin
				entry_d = upper;
			end
		end else begin
			// No command: the cell keeps its word.
			entry_d = entry_q;
		end
	end

	always_ff @(posedge clk) begin
		entry_q <= entry_d;
	end

	assign q = entry_q;

endmodule
